// ===== rtl/ptsch_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsch_pkg
// Types and constants shared by the periodic timer scheduler and its cells.
// ----------------------------------------------------------------------------
package ptsch_pkg;

   localparam int DEFAULT_TIMERS = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int CNT_W          = $clog2(MAX_RESULTS);
   localparam int TIME_W         = 32;
   localparam int PER_W          = 24;
   localparam int SLOT_W         = 4;
   localparam int KIND_W         = 2;
   localparam int STAT_W         = 2;

   localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

   localparam logic [STAT_W-1:0] STAT_ADDED   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EXPIRED = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DEL_ACK = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_FREE,
      OP_DEL,
      OP_REARM
   } ptsch_op_type;

   typedef enum logic {
      MODE_DUE,
      MODE_ADD
   } ptsch_mode_type;

   typedef struct packed {
      ptsch_op_type         op;
      ptsch_mode_type       mode;
      logic [SLOT_W-1:0]    tid;
      logic [PER_W-1:0]     per;
   } ptsch_cmd_type;

   typedef struct packed {
      logic go;
      logic hit;
   } ptsch_tok_type;

endpackage

// ===== rtl/ptsch_cell.sv =====
// ----------------------------------------------------------------------------
// ptsch_cell
// One timer slot. Holds deadline, period and busy/running marks, and passes
// the search token to the next cell, keeping the oldest due timer or
// claiming the token for an add.
// ----------------------------------------------------------------------------
module ptsch_cell
   import ptsch_pkg::*;
#(
   parameter int TIMERS = DEFAULT_TIMERS,
   parameter int INDEX  = 0,
   localparam int IW    = $clog2(TIMERS)
) (
   input  logic                clock,
   input  logic                reset,
   input  ptsch_cmd_type       cmd,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [IW-1:0]       rearm_idx,
   input  ptsch_tok_type       in_ctl,
   input  logic [TIME_W-1:0]   in_age,
   input  logic [IW-1:0]       in_idx,
   output ptsch_tok_type       out_ctl,
   output logic [TIME_W-1:0]   out_age,
   output logic [IW-1:0]       out_idx
);

   localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;

   logic                busy_ff, busy_in;
   logic                running_ff, running_in;
   logic [TIME_W-1:0]   deadline_ff, deadline_in;
   logic [PER_W-1:0]    period_ff, period_in;
   ptsch_tok_type       ctl_ff, ctl_in;
   logic [TIME_W-1:0]   age_ff, age_in;
   logic [IW-1:0]       idx_ff, idx_in;

   logic [TIME_W-1:0]   age;
   logic                expired;
   logic                due;
   logic                better;

   assign age     = now_ms - deadline_ff;
   assign expired = ~age[TIME_W-1];
   assign due     = busy_ff & running_ff & expired;
   assign better  = ~in_ctl.hit | (age > in_age);

   always_comb begin
      busy_in     = busy_ff;
      running_in  = running_ff;
      deadline_in = deadline_ff;
      period_in   = period_ff;
      ctl_in      = in_ctl;
      age_in      = in_age;
      idx_in      = in_idx;

      if (in_ctl.go) begin
         unique case (cmd.mode)
            MODE_DUE: begin
               if (due && better) begin
                  ctl_in.hit = 1'b1;
                  age_in     = age;
                  idx_in     = IW'(INDEX);
               end
            end
            MODE_ADD: begin
               if (!in_ctl.hit && !busy_ff) begin
                  busy_in     = 1'b1;
                  running_in  = 1'b1;
                  period_in   = cmd.per;
                  deadline_in = now_ms + TIME_W'(cmd.per);
                  ctl_in.hit  = 1'b1;
                  idx_in      = IW'(INDEX);
               end
            end
            default: ;
         endcase
      end

      unique case (cmd.op)
         OP_NONE: ;
         OP_FREE: begin
            if (busy_ff && !running_ff && expired) begin
               busy_in = 1'b0;
            end
         end
         OP_DEL: begin
            if (CW'(cmd.tid) == CW'(INDEX)) begin
               running_in = 1'b0;
            end
         end
         OP_REARM: begin
            if (rearm_idx == IW'(INDEX)) begin
               deadline_in = now_ms + TIME_W'(period_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         running_ff <= 1'b0;
         ctl_ff     <= '0;
      end else begin
         busy_ff    <= busy_in;
         running_ff <= running_in;
         ctl_ff     <= ctl_in;
      end
      deadline_ff <= deadline_in;
      period_ff   <= period_in;
      age_ff      <= age_in;
      idx_ff      <= idx_in;
   end

   assign out_ctl = ctl_ff;
   assign out_age = age_ff;
   assign out_idx = idx_ff;

endmodule

// ===== rtl/periodic_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler
// Table of periodic millisecond timers kept in a row of slot cells, with a
// millisecond time counter; handles add, delete and tick items.
// ----------------------------------------------------------------------------
// A delete leaves busy low. An add makes one token pass down the row of
// cells, which finds the lowest free slot. In a tick, each pass of the
// search token through the cell row selects the oldest due timer, which
// is then re-armed. Results come as one-cycle strobes on the rsp_ ports and
// cannot be held off; rsp_last marks the final result of an item. Timers of
// a delete stay in their slot until their deadline passes.
// ----------------------------------------------------------------------------
module periodic_timer_scheduler
   import ptsch_pkg::*;
#(
   parameter int TIMERS = DEFAULT_TIMERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SLOT_W-1:0]   req_timer_id,
   input  logic [PER_W-1:0]    req_period_ms,
   output logic                rsp_strobe,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_id,
   output logic                rsp_last
);

   localparam int IW = $clog2(TIMERS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_TICK,
      ST_REARM,
      ST_FLUSH
   } state_type;

   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   ptsch_cmd_type       cmd_ff, cmd_in;
   logic                inj_ff, inj_in;
   logic [IW-1:0]       rearm_ff, rearm_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_v_ff, pend_v_in;
   logic [IW-1:0]       pend_idx_ff, pend_idx_in;
   logic                strobe_ff, strobe_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                last_ff, last_in;

   ptsch_tok_type       tok_ctl [0:TIMERS];
   logic [TIME_W-1:0]   tok_age [0:TIMERS];
   logic [IW-1:0]       tok_idx [0:TIMERS];

   logic                accept;
   ptsch_tok_type       end_ctl;
   logic [IW-1:0]       end_idx;
   logic [PER_W-1:0]    per_clamped;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start & ~busy;
   assign end_ctl     = tok_ctl[TIMERS];
   assign end_idx     = tok_idx[TIMERS];
   assign per_clamped = (req_period_ms == '0) ? PER_W'(1) : req_period_ms;

   assign tok_ctl[0] = '{go: inj_ff, hit: 1'b0};
   assign tok_age[0] = '0;
   assign tok_idx[0] = '0;

   for (genvar g = 0; g < TIMERS; g++) begin : g_cell
      ptsch_cell #(
         .TIMERS (TIMERS),
         .INDEX  (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd_ff),
         .now_ms    (now_ff),
         .rearm_idx (rearm_ff),
         .in_ctl    (tok_ctl[g]),
         .in_age    (tok_age[g]),
         .in_idx    (tok_idx[g]),
         .out_ctl   (tok_ctl[g+1]),
         .out_age   (tok_age[g+1]),
         .out_idx   (tok_idx[g+1])
      );
   end

   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      cmd_in      = cmd_ff;
      cmd_in.op   = OP_NONE;
      inj_in      = 1'b0;
      rearm_in    = rearm_ff;
      cnt_in      = cnt_ff;
      pend_v_in   = pend_v_ff;
      pend_idx_in = pend_idx_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      slot_in     = slot_ff;
      last_in     = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_ADD: begin
                     cmd_in.mode = MODE_ADD;
                     cmd_in.per  = per_clamped;
                     inj_in      = 1'b1;
                     state_in    = ST_ADD;
                  end
                  KIND_DEL: begin
                     cmd_in.op  = OP_DEL;
                     cmd_in.tid = req_timer_id;
                     strobe_in  = 1'b1;
                     status_in  = STAT_DEL_ACK;
                     slot_in    = req_timer_id;
                     last_in    = 1'b1;
                  end
                  KIND_TICK: begin
                     now_in      = now_ff + TIME_W'(1);
                     cmd_in.op   = OP_FREE;
                     cmd_in.mode = MODE_DUE;
                     inj_in      = 1'b1;
                     cnt_in      = '0;
                     pend_v_in   = 1'b0;
                     state_in    = ST_TICK;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            if (end_ctl.go) begin
               strobe_in = 1'b1;
               status_in = end_ctl.hit ? STAT_ADDED : STAT_FULL;
               slot_in   = end_ctl.hit ? SLOT_W'(end_idx) : '0;
               last_in   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (end_ctl.go) begin
               if (end_ctl.hit) begin
                  cmd_in.op   = OP_REARM;
                  rearm_in    = end_idx;
                  pend_v_in   = 1'b1;
                  pend_idx_in = end_idx;
                  cnt_in      = cnt_ff + CNT_W'(1);
                  if (pend_v_ff) begin
                     strobe_in = 1'b1;
                     status_in = STAT_EXPIRED;
                     slot_in   = SLOT_W'(pend_idx_ff);
                     last_in   = 1'b0;
                  end
                  state_in = (cnt_ff == CNT_W'(MAX_RESULTS - 1)) ? ST_FLUSH : ST_REARM;
               end else begin
                  if (pend_v_ff) begin
                     strobe_in = 1'b1;
                     status_in = STAT_EXPIRED;
                     slot_in   = SLOT_W'(pend_idx_ff);
                     last_in   = 1'b1;
                  end
                  pend_v_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_REARM: begin
            inj_in   = 1'b1;
            state_in = ST_TICK;
         end
         ST_FLUSH: begin
            strobe_in = 1'b1;
            status_in = STAT_EXPIRED;
            slot_in   = SLOT_W'(pend_idx_ff);
            last_in   = 1'b1;
            pend_v_in = 1'b0;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         now_ff    <= '0;
         cmd_ff    <= '{op: OP_NONE, mode: MODE_DUE, tid: '0, per: '0};
         inj_ff    <= 1'b0;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         now_ff    <= now_in;
         cmd_ff    <= cmd_in;
         inj_ff    <= inj_in;
         cnt_ff    <= cnt_in;
         pend_v_ff <= pend_v_in;
         strobe_ff <= strobe_in;
      end
      rearm_ff    <= rearm_in;
      pend_idx_ff <= pend_idx_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_status  = status_ff;
   assign rsp_slot_id = slot_ff;
   assign rsp_last    = last_ff;

`ifndef SYNTHESIS
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      end_ctl.go |-> (state_ff == ST_ADD || state_ff == ST_TICK))
      else $error("search token left the cell row outside a scan");

   a_add_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_ADD) |=> busy)
      else $error("add item did not start a slot search");

   a_del_ack: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_DEL) |=>
         (rsp_strobe && rsp_status == STAT_DEL_ACK && rsp_last))
      else $error("delete item not acknowledged in the next cycle");

   a_flush_has_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> pend_v_ff)
      else $error("flush without a pending expired item");
`endif

endmodule

// ===== test/periodic_timer_scheduler_checker.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_checker
// Watches the item and result channels of the timer scheduler, keeps its own
// timer table and time counter, and compares every result strobe with the
// oldest predicted one, field by field. Reports the mismatch count and the
// number of results still owed.
// ----------------------------------------------------------------------------
module periodic_timer_scheduler_checker
   import ptsch_pkg::*;
#(
   parameter int TIMERS = DEFAULT_TIMERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SLOT_W-1:0]   req_timer_id,
   input  logic [PER_W-1:0]    req_period_ms,
   input  logic                rsp_strobe,
   input  logic [STAT_W-1:0]   rsp_status,
   input  logic [SLOT_W-1:0]   rsp_slot_id,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  owed_count
);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } timer_rsp_type;

   timer_rsp_type       owed_rsp_q[$];
   logic [TIME_W-1:0]   now_ms;
   logic [TIME_W-1:0]   tmr_deadline [TIMERS];
   logic [PER_W-1:0]    tmr_period [TIMERS];
   logic [TIMERS-1:0]   tmr_busy;
   logic [TIMERS-1:0]   tmr_running;
   int                  mismatches = 0;
   int                  owed = 0;

   assign fail_count = mismatches;
   assign owed_count = owed;

   function automatic logic deadline_passed(input logic [TIME_W-1:0] d);
      logic [TIME_W-1:0] diff;
      diff = now_ms - d;
      return !diff[TIME_W-1];
   endfunction

   function automatic void owe_rsp(input logic [STAT_W-1:0] status,
                                   input logic [SLOT_W-1:0] slot,
                                   input logic last);
      timer_rsp_type r;
      r.status = status;
      r.slot   = slot;
      r.last   = last;
      owed_rsp_q.push_back(r);
   endfunction

   task automatic run_timer_item(input logic [KIND_W-1:0] kind,
                                 input logic [SLOT_W-1:0] tid,
                                 input logic [PER_W-1:0] per);
      logic [PER_W-1:0]  eff_per;
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] best_age;
      logic [SLOT_W-1:0] fired [MAX_RESULTS];
      int                free_slot;
      int                best;
      int                n;
      eff_per   = (per == '0) ? PER_W'(1) : per;
      free_slot = -1;
      best_age  = '0;
      n         = 0;
      case (kind)
         KIND_ADD: begin
            for (int i = 0; i < TIMERS; i++) begin
               if (!tmr_busy[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot >= 0) begin
               tmr_busy[free_slot]     = 1'b1;
               tmr_running[free_slot]  = 1'b1;
               tmr_period[free_slot]   = eff_per;
               tmr_deadline[free_slot] = now_ms + TIME_W'(eff_per);
               owe_rsp(STAT_ADDED, SLOT_W'(free_slot), 1'b1);
            end else begin
               owe_rsp(STAT_FULL, '0, 1'b1);
            end
         end
         KIND_DEL: begin
            if (int'(tid) < TIMERS) tmr_running[tid] = 1'b0;
            owe_rsp(STAT_DEL_ACK, tid, 1'b1);
         end
         KIND_TICK: begin
            now_ms = now_ms + 1;
            // stopped timers give their slot back once the deadline passes
            for (int i = 0; i < TIMERS; i++) begin
               if (tmr_busy[i] && !tmr_running[i] && deadline_passed(tmr_deadline[i]))
                  tmr_busy[i] = 1'b0;
            end
            best = 0;
            while (n < MAX_RESULTS && best >= 0) begin
               best = -1;
               for (int i = 0; i < TIMERS; i++) begin
                  if (tmr_busy[i] && tmr_running[i] && deadline_passed(tmr_deadline[i]))
                  begin
                     age = now_ms - tmr_deadline[i];
                     if (best < 0 || age > best_age) begin
                        best     = i;
                        best_age = age;
                     end
                  end
               end
               if (best >= 0) begin
                  tmr_deadline[best] = now_ms + TIME_W'(tmr_period[best]);
                  fired[n] = SLOT_W'(best);
                  n++;
               end
            end
            for (int k = 0; k < n; k++) owe_rsp(STAT_EXPIRED, fired[k], k == n - 1);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         now_ms      = '0;
         tmr_busy    = '0;
         tmr_running = '0;
         for (int i = 0; i < TIMERS; i++) begin
            tmr_deadline[i] = '0;
            tmr_period[i]   = '0;
         end
         owed_rsp_q.delete();
      end else begin
         if (start && !busy) run_timer_item(req_kind, req_timer_id, req_period_ms);
         if (rsp_strobe === 1'b1) begin
            if (owed_rsp_q.size() == 0) begin
               $error("unexpected result: rsp_status %0d rsp_slot_id %0d rsp_last %0d",
                      rsp_status, rsp_slot_id, rsp_last);
               mismatches++;
            end else begin
               timer_rsp_type want;
               want = owed_rsp_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status expected %0d actual %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_slot_id !== want.slot) begin
                  $error("rsp_slot_id expected %0d actual %0d", want.slot, rsp_slot_id);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last expected %0d actual %0d", want.last, rsp_last);
                  mismatches++;
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            $error("rsp_strobe expected 0 or 1 actual %b", rsp_strobe);
            mismatches++;
         end
      end
      owed = owed_rsp_q.size();
   end

endmodule

// ===== test/tb_periodic_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_timer_scheduler
// Drives add, delete and tick items into the timer scheduler: a directed run
// over clamped and maximum periods, deletes of free and stopped slots, a full
// table and a tick that fires every running slot, then random traffic with
// random gaps. A checker beside the block predicts and compares all results.
// ----------------------------------------------------------------------------
module tb_periodic_timer_scheduler;
   import ptsch_pkg::*;

   localparam int TIMERS = DEFAULT_TIMERS;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 95;
   localparam int DRAIN_CYCLES = 20 * (TIMERS + 2);

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [SLOT_W-1:0]   req_timer_id;
   logic [PER_W-1:0]    req_period_ms;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_id;
   logic                rsp_last;
   int                  fail_count;
   int                  owed_count;
   int                  no_gap_left = 0;

   periodic_timer_scheduler #(.TIMERS(TIMERS)) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_timer_id  (req_timer_id),
      .req_period_ms (req_period_ms),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_slot_id   (rsp_slot_id),
      .rsp_last      (rsp_last)
   );

   periodic_timer_scheduler_checker #(.TIMERS(TIMERS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_timer_id  (req_timer_id),
      .req_period_ms (req_period_ms),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_slot_id   (rsp_slot_id),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .owed_count    (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic [SLOT_W-1:0] tid,
                            input logic [PER_W-1:0] per);
      int gap;
      int r;
      r = $urandom_range(99);
      if (no_gap_left > 0) begin
         no_gap_left--;
         gap = 0;
      end else if (r < 12) begin
         no_gap_left = $urandom_range(12, 4);
         gap = 0;
      end else if (r < 50) begin
         gap = 0;
      end else if (r < 92) begin
         gap = $urandom_range(4, 1);
      end else begin
         gap = $urandom_range(60, 20);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_timer_id  <= tid;
      req_period_ms <= per;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [PER_W-1:0] pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 70) return PER_W'($urandom_range(6, 0));
      else if (r < 85) return PER_W'($urandom_range(40, 7));
      else return PER_W'($urandom());
   endfunction

   initial begin
      logic [KIND_W-1:0] kind;
      int                r;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_kind      <= KIND_TICK;
      req_timer_id  <= '0;
      req_period_ms <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // quiet tick, ignored kind, clamped period and its expiry
      send_item(KIND_TICK, 4'd0, '0);
      send_item(KIND_UNUSED, 4'd15, {PER_W{1'b1}});
      send_item(KIND_ADD, 4'd0, '0);
      send_item(KIND_TICK, 4'd0, '0);
      // longest period, then deletes of a running, stopped and free slot
      send_item(KIND_ADD, 4'd15, {PER_W{1'b1}});
      send_item(KIND_DEL, 4'd1, '0);
      send_item(KIND_DEL, 4'd1, '0);
      send_item(KIND_DEL, 4'd15, '0);
      // fill the table, overflow it, then fire every running slot at once
      for (int i = 0; i < TIMERS - 2; i++) send_item(KIND_ADD, 4'd0, PER_W'(1));
      send_item(KIND_ADD, 4'd0, PER_W'(1));
      send_item(KIND_TICK, 4'd0, '0);
      send_item(KIND_TICK, 4'd0, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(99);
         if (r < 30) kind = KIND_ADD;
         else if (r < 52) kind = KIND_DEL;
         else if (r < 95) kind = KIND_TICK;
         else kind = KIND_UNUSED;
         send_item(kind, SLOT_W'($urandom_range(15, 0)), pick_period());
      end
      start <= 1'b0;

      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && owed_count == 0) begin
         $display("periodic_timer_scheduler verification clean");
      end else begin
         $display("periodic_timer_scheduler verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("periodic_timer_scheduler verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ptsch_pkg.sv
rtl/ptsch_cell.sv
rtl/periodic_timer_scheduler.sv
test/periodic_timer_scheduler_checker.sv
test/tb_periodic_timer_scheduler.sv
